### rtl/core/lps_pkg.sv
// lps_pkg: shared types and constants for the line pattern search block.
// No dependencies; imported by lps_cell, lps_seg_ctrl, line_pattern_search and the bench.
package lps_pkg;

  localparam logic [7:0] CHAR_NL  = 8'd10;
  localparam logic [7:0] CHAR_SP  = 8'd32;
  localparam logic [7:0] CHAR_NUL = 8'd0;

  // Pattern registers hold 32 bytes; a wider chain has nothing to compare against.
  localparam int unsigned REG_BYTES = 32;

  localparam logic [9:0] DONE_MAX    = 10'd1023;
  localparam logic [9:0] LIMIT_RESET = 10'd251;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned PLEN_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT0  = 3'd0,
    REG_PAT1  = 3'd1,
    REG_PAT2  = 3'd2,
    REG_PAT3  = 3'd3,
    REG_PLEN  = 3'd4,
    REG_LIMIT = 3'd5
  } cfg_reg_t;

  // Per-byte command from the segment control to the cell chain.
  typedef struct packed {
    logic shift;   // word byte: advance the prefix-match chain
    logic clear;   // word or segment break: drop all partial matches
  } lps_step_t;

endpackage

### rtl/core/lps_cell.sv
// lps_cell: one prefix-match cell; holds "last j+1 bytes equal pattern[0..j]".
// Depends on lps_pkg (lps_step_t).
module lps_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  lps_pkg::lps_step_t step,
  input  logic [7:0]        byte_in,
  input  logic [7:0]        pat_byte,
  input  logic              prev_in,
  output logic              hit_nxt,
  output logic              hit_q
);
  import lps_pkg::*;

  logic hit_r;
  logic hit_nxt_c;

  always_comb begin
    priority if (step.clear) begin
      hit_nxt_c = 1'b0;
    end else if (step.shift) begin
      hit_nxt_c = prev_in && (byte_in == pat_byte);
    end else begin
      hit_nxt_c = hit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt_c;
    end
  end

  assign hit_nxt = hit_nxt_c;
  assign hit_q   = hit_r;

endmodule

### rtl/core/lps_seg_ctrl.sv
// lps_seg_ctrl: segment byte count, line limit, match flag and output register.
// Depends on lps_pkg (constants, lps_step_t).
module lps_seg_ctrl #(
  parameter int unsigned MAX_SEGMENT = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_accept,
  input  logic [7:0]         byte_value,
  input  logic               end_of_input,
  input  logic [9:0]         line_limit,
  input  logic               word_hit,
  output lps_pkg::lps_step_t step,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_matched,
  output logic [7:0]         out_segment_length,
  output logic [9:0]         out_segment_index
);
  import lps_pkg::*;

  // at least 8 bits so the length field is always a slice of the count
  localparam int unsigned CW = ($clog2(MAX_SEGMENT + 1) > 8) ? $clog2(MAX_SEGMENT + 1) : 8;

  logic [CW-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [9:0]    done_r, done_nxt;
  logic          seg_hit_r, seg_hit_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_matched_r;
  logic [7:0]    out_len_r;
  logic [9:0]    out_idx_r;
  logic          active, ends, sep, take, emit;

  assign active  = (done_r < line_limit);
  assign take    = in_accept && active;
  assign cnt_inc = cnt_r + CW'(1);
  assign ends    = (byte_value == CHAR_NL) || end_of_input || (cnt_inc >= CW'(MAX_SEGMENT));
  assign sep     = (byte_value == CHAR_SP) || (byte_value == CHAR_NUL);
  assign emit    = take && ends;

  assign step.shift = take && !ends && !sep;
  assign step.clear = take && (ends || sep);

  always_comb begin
    cnt_nxt     = cnt_r;
    done_nxt    = done_r;
    seg_hit_nxt = seg_hit_r;
    if (emit) begin
      cnt_nxt     = '0;
      seg_hit_nxt = 1'b0;
      if (done_r < DONE_MAX) begin
        done_nxt = done_r + 10'd1;
      end
    end else if (take) begin
      cnt_nxt = cnt_inc;
      if (word_hit) begin
        seg_hit_nxt = 1'b1;
      end
    end
    out_valid_nxt = (out_valid_r && !out_ready) || emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      done_r      <= '0;
      seg_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      done_r      <= done_nxt;
      seg_hit_r   <= seg_hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (emit) begin
      out_matched_r <= seg_hit_r;
      out_len_r     <= cnt_inc[7:0];
      out_idx_r     <= done_r;
    end
  end

  assign in_ready           = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_matched        = out_matched_r;
  assign out_segment_length = out_len_r;
  assign out_segment_index  = out_idx_r;

endmodule

### rtl/core/line_pattern_search.sv
// line_pattern_search: one byte accepted per cycle, sustained, while out_ready holds.
// The result of a segment is shown in the cycle after its ending byte is accepted.
// Throughput is set by the shift-and update of the whole cell chain on each accepted byte.
// Reset (rst_n low, synchronous): pattern cleared, length 0, limit 251, counters zero.
module line_pattern_search #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned MAX_SEGMENT = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // input request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_end_of_input,
  // result request channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_matched,
  output logic [7:0]  out_segment_length,
  output logic [9:0]  out_segment_index
);
  import lps_pkg::*;

  // Cells past the 32 configurable pattern bytes could never match.
  localparam int unsigned NCELL = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [3:0][63:0]    pattern_r;
  logic [PLEN_W-1:0]   plen_r;
  logic [9:0]          limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      plen_r    <= '0;
      limit_r   <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PAT0:  pattern_r[0] <= cfg_data;
        REG_PAT1:  pattern_r[1] <= cfg_data;
        REG_PAT2:  pattern_r[2] <= cfg_data;
        REG_PAT3:  pattern_r[3] <= cfg_data;
        REG_PLEN:  plen_r       <= cfg_data[PLEN_W-1:0];
        REG_LIMIT: limit_r      <= cfg_data[9:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Segment control and output register
  // ---------------------------------------------------------------------
  lps_step_t  step;
  logic       in_accept;
  logic       word_hit;

  assign in_accept = in_valid && in_ready;

  lps_seg_ctrl #(
    .MAX_SEGMENT (MAX_SEGMENT)
  ) u_seg (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_accept          (in_accept),
    .byte_value         (in_byte_value),
    .end_of_input       (in_end_of_input),
    .line_limit         (limit_r),
    .word_hit           (word_hit),
    .step               (step),
    .in_ready           (in_ready),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_matched        (out_matched),
    .out_segment_length (out_segment_length),
    .out_segment_index  (out_segment_index)
  );

  // ---------------------------------------------------------------------
  // Cell chain (shift-and). Cell j is set when the current word ends in
  // pattern[0..j]; each word byte moves the set bits one cell up, gated by
  // that cell's pattern byte. Spaces, zero bytes and segment ends clear it.
  // Long words need no window: only prefix state is kept.
  // ---------------------------------------------------------------------
  logic [NCELL-1:0] cell_q;
  logic [NCELL-1:0] cell_nxt;
  logic [NCELL-1:0] len_sel;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    logic prev;
    if (j == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = cell_q[j-1];
    end

    lps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (step),
      .byte_in  (in_byte_value),
      .pat_byte (pattern_r[j/8][(j%8)*8 +: 8]),
      .prev_in  (prev),
      .hit_nxt  (cell_nxt[j]),
      .hit_q    (cell_q[j])
    );

    // Full match is the cell at pattern_length-1; length 0 or past the
    // chain selects nothing and so never matches.
    assign len_sel[j] = (plen_r == PLEN_W'(j + 1));
  end

  assign word_hit = step.shift && (|(cell_nxt & len_sel));

endmodule

### rtl/core/lps_checker.sv
// lps_checker: port-level assertions for line_pattern_search, with its bind.
// Depends only on the top level's ports.
module lps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_matched,
  input logic [7:0] out_segment_length,
  input logic [9:0] out_segment_index
);

  // A held result keeps its payload until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_matched)
      && $stable(out_segment_length) && $stable(out_segment_index))
    else $error("result changed while stalled");

  // Input stalls only behind a pending result.
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // A new result needs an accepted byte in the cycle before.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without an input byte");

  // While a result is being taken, the input is ready.
  a_take_then_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> in_ready)
    else $error("ready low while result drains");

endmodule

bind line_pattern_search lps_checker u_lps_checker (.*);

### bench/tb_line_pattern_search.sv
// tb_line_pattern_search: self-checking bench for the line pattern search block.
// Depends on lps_pkg and line_pattern_search; a directed script is followed by
// random text phases, results compared against an in-bench segment judge or a typed verdict.
module tb_line_pattern_search;
  timeunit 1ns;
  timeprecision 1ps;

  import lps_pkg::*;

  localparam int unsigned MAX_PATTERN = 32;
  localparam int unsigned MAX_SEGMENT = 255;
  // Bytes of pattern that can ever be compared.
  localparam int unsigned PAT_CAP = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
  localparam int unsigned TARGET_BYTES = 1250;

  // One judged segment as it leaves the block.
  typedef struct packed {
    logic       matched;
    logic [7:0] seg_len;
    logic [9:0] seg_idx;
  } verdict_t;

  // Directed script rows: plain text, text whose verdict is typed in, register write.
  typedef enum logic [1:0] {
    ROW_TEXT,
    ROW_JUDGED,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_reg_t    sel;
    logic [63:0] value;   // register data, or the text byte in bits 7:0
    logic        last;
    verdict_t    want;
  } script_row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } plan_byte_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte_value;
  logic        in_end_of_input;
  logic        out_valid;
  logic        out_ready;
  logic        out_matched;
  logic [7:0]  out_segment_length;
  logic [9:0]  out_segment_index;

  line_pattern_search #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_SEGMENT(MAX_SEGMENT)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_value     (in_byte_value),
    .in_end_of_input   (in_end_of_input),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_matched       (out_matched),
    .out_segment_length(out_segment_length),
    .out_segment_index (out_segment_index)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the configuration registers and of the block's search state.
  // ---------------------------------------------------------------------------
  logic [63:0] pat_word [4];
  logic [5:0]  pat_len;
  logic [9:0]  seg_limit;

  logic [7:0]  word_tail [MAX_PATTERN];  // last bytes of the current word, newest at top
  int          tail_fill;
  bit          seg_hit;
  int          seg_bytes;
  int          segs_judged;

  verdict_t    pending_verdicts [$];     // segments judged, not yet seen at the output
  plan_byte_t  text_plan [$];            // text of the current random phase
  int          mismatch_count;
  int          fed_bytes;                // bytes the block actually took into account
  bit          no_idle;                  // burst stretch: neither side idles

  // Directed script. Verdicts are typed in only where they are obvious.
  script_row_t dir_script [32] = '{
    // after reset: empty pattern never matches
    '{ROW_TEXT,   REG_PAT0,  64'h61,     1'b0, '0},
    '{ROW_JUDGED, REG_PAT0,  64'h0a,     1'b0, '{1'b0, 8'd2, 10'd0}},
    // pattern "ab"
    '{ROW_CFG,    REG_PAT0,  64'h6261,   1'b0, '0},
    '{ROW_CFG,    REG_PLEN,  64'd2,      1'b0, '0},
    '{ROW_TEXT,   REG_PAT0,  64'h78,     1'b0, '0},
    '{ROW_TEXT,   REG_PAT0,  64'h61,     1'b0, '0},
    '{ROW_TEXT,   REG_PAT0,  64'h62,     1'b0, '0},
    '{ROW_JUDGED, REG_PAT0,  64'h0a,     1'b0, '{1'b1, 8'd4, 10'd1}},
    // space splits the word; end of input closes the segment
    '{ROW_TEXT,   REG_PAT0,  64'h61,     1'b0, '0},
    '{ROW_TEXT,   REG_PAT0,  64'h20,     1'b0, '0},
    '{ROW_JUDGED, REG_PAT0,  64'h62,     1'b1, '{1'b0, 8'd3, 10'd2}},
    // the ending byte is never examined
    '{ROW_TEXT,   REG_PAT0,  64'h61,     1'b0, '0},
    '{ROW_JUDGED, REG_PAT0,  64'h62,     1'b1, '{1'b0, 8'd2, 10'd3}},
    // top byte value is an ordinary word character
    '{ROW_TEXT,   REG_PAT0,  64'hff,     1'b0, '0},
    '{ROW_TEXT,   REG_PAT0,  64'h61,     1'b0, '0},
    '{ROW_TEXT,   REG_PAT0,  64'h62,     1'b0, '0},
    '{ROW_JUDGED, REG_PAT0,  64'h0a,     1'b0, '{1'b1, 8'd4, 10'd4}},
    // limit reached: bytes dropped silently, then limit zero, then widest
    '{ROW_CFG,    REG_LIMIT, 64'd5,      1'b0, '0},
    '{ROW_TEXT,   REG_PAT0,  64'h7a,     1'b1, '0},
    '{ROW_CFG,    REG_LIMIT, 64'd0,      1'b0, '0},
    '{ROW_TEXT,   REG_PAT0,  64'h0a,     1'b0, '0},
    '{ROW_CFG,    REG_LIMIT, 64'd1023,   1'b0, '0},
    // pattern length beyond the register file never matches
    '{ROW_CFG,    REG_PLEN,  64'd63,     1'b0, '0},
    '{ROW_TEXT,   REG_PAT0,  64'h61,     1'b0, '0},
    '{ROW_TEXT,   REG_PAT0,  64'h62,     1'b0, '0},
    '{ROW_JUDGED, REG_PAT0,  64'h0a,     1'b0, '{1'b0, 8'd3, 10'd5}},
    // zero byte inside the pattern: text zero is a separator, so no match
    '{ROW_CFG,    REG_PAT0,  64'h620061, 1'b0, '0},
    '{ROW_CFG,    REG_PLEN,  64'd3,      1'b0, '0},
    '{ROW_TEXT,   REG_PAT0,  64'h61,     1'b0, '0},
    '{ROW_TEXT,   REG_PAT0,  64'h00,     1'b0, '0},
    '{ROW_TEXT,   REG_PAT0,  64'h62,     1'b0, '0},
    '{ROW_JUDGED, REG_PAT0,  64'h0a,     1'b0, '{1'b0, 8'd4, 10'd6}}
  };

  // ---------------------------------------------------------------------------
  // Segment judge
  // ---------------------------------------------------------------------------
  function automatic void clear_tail();
    for (int i = 0; i < MAX_PATTERN; i++) word_tail[i] = '0;
    tail_fill = 0;
  endfunction

  // Does the current word end with the configured pattern?
  function automatic bit tail_matches();
    int n;
    n = int'(pat_len);
    if (n == 0 || n > PAT_CAP || tail_fill < n) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (word_tail[MAX_PATTERN - n + i] != pat_word[i / 8][(i % 8) * 8 +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the shadow state by one accepted byte; returns 1 when a segment closes.
  function automatic bit judge_text_byte(input logic [7:0] b, input bit last,
                                         output verdict_t v);
    bit ends;
    v = '0;
    if (segs_judged >= int'(seg_limit)) return 1'b0;  // past the limit: byte dropped
    seg_bytes++;
    ends = (b == CHAR_NL) || last || (seg_bytes >= MAX_SEGMENT);
    if (!ends) begin
      if (b == CHAR_SP || b == CHAR_NUL) begin
        clear_tail();
      end else begin
        for (int i = 0; i < MAX_PATTERN - 1; i++) word_tail[i] = word_tail[i + 1];
        word_tail[MAX_PATTERN - 1] = b;
        if (tail_fill < MAX_PATTERN) tail_fill++;
        if (tail_matches()) seg_hit = 1'b1;
      end
      return 1'b0;
    end
    // closing byte: counted, not examined
    v.matched = seg_hit;
    v.seg_len = seg_bytes[7:0];
    v.seg_idx = segs_judged[9:0];
    clear_tail();
    seg_hit = 1'b0;
    seg_bytes = 0;
    if (segs_judged < int'(DONE_MAX)) segs_judged++;
    return 1'b1;
  endfunction

  // Mostly a tiny alphabet so patterns recur; tabs and arbitrary bytes mixed in.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'($urandom_range(0, 255));
    if (r == 1) return 8'h09;
    return 8'h61 + 8'($urandom_range(0, 3));
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Register write; the shadow follows at the same edge. cfg_we is lowered by the caller.
  task automatic write_reg(input cfg_reg_t sel, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    case (sel)
      REG_PAT0: pat_word[0] = val;
      REG_PAT1: pat_word[1] = val;
      REG_PAT2: pat_word[2] = val;
      REG_PAT3: pat_word[3] = val;
      REG_PLEN: pat_len = val[5:0];
      REG_LIMIT: seg_limit = val[9:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Send one byte request; once taken, judge it and queue the verdict if any.
  task automatic feed_byte(input logic [7:0] b, input bit last, input bit typed,
                           input verdict_t typed_v);
    int gap;
    bit live;
    verdict_t v;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_byte_value   <= b;
    in_end_of_input <= last;
    do @(posedge clk); while (!in_ready);
    live = segs_judged < int'(seg_limit);
    if (judge_text_byte(b, last, v)) pending_verdicts.push_back(typed ? typed_v : v);
    if (live) fed_bytes++;
  endtask

  // Stop sending and wait for every verdict, then idle further so that nothing
  // is still in flight when the registers change.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One line segment of random words, optionally long enough to hit MAX_SEGMENT.
  task automatic plan_segment(input bit long_line);
    int words;
    int wl;
    int plant_at;
    int r;
    words = long_line ? $urandom_range(45, 70) : $urandom_range(1, 6);
    for (int w = 0; w < words; w++) begin
      // now and then a word longer than the window
      wl = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 50) : $urandom_range(1, 10);
      plant_at = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, wl)) : -1;
      for (int k = 0; k <= wl; k++) begin
        if (k == plant_at) begin
          for (int p = 0; p < int'(pat_len) && p < REG_BYTES; p++)
            text_plan.push_back('{pat_word[p / 8][(p % 8) * 8 +: 8], 1'b0});
        end
        if (k < wl) text_plan.push_back('{pick_char(), 1'b0});
      end
      if (w < words - 1) begin
        text_plan.push_back('{($urandom_range(0, 4) == 0) ? CHAR_NUL : CHAR_SP, 1'b0});
        if ($urandom_range(0, 7) == 0) text_plan.push_back('{CHAR_SP, 1'b0});
      end
    end
    r = $urandom_range(0, 9);
    if (r == 0)
      text_plan[text_plan.size() - 1].last = 1'b1;  // end of input on a word byte
    else if (r == 1)
      text_plan.push_back('{CHAR_NL, 1'b1});        // end of input on the newline
    else if (r != 2)
      text_plan.push_back('{CHAR_NL, 1'b0});        // r == 2: runs into the next line
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, result side
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: a fresh random stall before each result request, none in a burst stretch.
  initial begin
    int stall;
    out_ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Every accepted result is matched against the oldest pending verdict.
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result request with no segment pending (index %0d)", out_segment_index);
        mismatch_count++;
      end else begin
        v = pending_verdicts.pop_front();
        check_field("matched", v.matched, out_matched);
        check_field("segment_length", v.seg_len, out_segment_length);
        check_field("segment_index", v.seg_idx, out_segment_index);
      end
    end
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb_line_pattern_search: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    bit cfg_active;
    int phase_no;
    int r;
    int lim;
    int plen;
    logic [63:0] new_pat [4];

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    in_byte_value   <= '0;
    in_end_of_input <= 1'b0;
    mismatch_count  = 0;
    fed_bytes       = 0;
    no_idle         = 1'b0;
    // shadow matches the block's reset state
    for (int j = 0; j < 4; j++) pat_word[j] = '0;
    pat_len     = '0;
    seg_limit   = LIMIT_RESET;
    clear_tail();
    seg_hit     = 1'b0;
    seg_bytes   = 0;
    segs_judged = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed script: register rows are only written with the block idle.
    cfg_active = 1'b0;
    foreach (dir_script[i]) begin
      if (dir_script[i].kind == ROW_CFG) begin
        if (!cfg_active) drain_results();
        write_reg(dir_script[i].sel, dir_script[i].value);
        cfg_active = 1'b1;
      end else begin
        if (cfg_active) cfg_we <= 1'b0;
        cfg_active = 1'b0;
        feed_byte(dir_script[i].value[7:0], dir_script[i].last,
                  dir_script[i].kind == ROW_JUDGED, dir_script[i].want);
      end
    end

    // Random phases: drain, reprogram every register, then a few lines of text.
    fed_bytes = 0;
    phase_no  = 0;
    while (fed_bytes < TARGET_BYTES) begin
      drain_results();
      no_idle = ($urandom_range(0, 3) == 0);

      if ($urandom_range(0, 9) == 0) begin
        for (int j = 0; j < 4; j++) new_pat[j] = {$urandom, $urandom};
      end else begin
        for (int j = 0; j < REG_BYTES; j++) new_pat[j / 8][(j % 8) * 8 +: 8] = pick_char();
      end
      r = $urandom_range(0, 19);
      if (r == 0)      plen = 0;
      else if (r == 1) plen = 32;
      else if (r == 2) plen = $urandom_range(33, 63);
      else if (r == 3) plen = $urandom_range(5, 31);
      else             plen = $urandom_range(1, 4);
      // mostly no limit; sometimes it runs out inside the phase or at once
      r = $urandom_range(0, 9);
      if (r == 0)      lim = segs_judged;
      else if (r < 3)  lim = segs_judged + $urandom_range(1, 5);
      else             lim = 1023;
      if (lim > 1023) lim = 1023;

      for (int j = 0; j < 4; j++) write_reg(cfg_reg_t'(j), new_pat[j]);
      write_reg(REG_PLEN, 64'(plen));
      write_reg(REG_LIMIT, 64'(lim));
      cfg_we <= 1'b0;

      text_plan.delete();
      r = $urandom_range(2, 8);
      for (int s = 0; s < r; s++)
        plan_segment(s == 0 && (phase_no == 1 || $urandom_range(0, 9) == 0));
      foreach (text_plan[k]) feed_byte(text_plan[k].b, text_plan[k].last, 1'b0, '0);
      phase_no++;
    end

    // Everything sent: wait for the last verdicts, then watch for strays.
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_line_pattern_search: clean");
    else
      $display("tb_line_pattern_search: errors");
    $finish;
  end

endmodule
